@@ design/hff_pkg.sv @@
// ---------------------------------------------------------------------------
// hff_pkg
// shared types, character codes and the hex digit function of the formatter
// ---------------------------------------------------------------------------
package hff_pkg;

  // ascii codes
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_X_LOWER = 8'h78;
  localparam logic [7:0] CH_X_UPPER = 8'h58;
  localparam logic [7:0] CH_A_LOWER = 8'h61;
  localparam logic [7:0] CH_A_UPPER = 8'h41;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned NIBBLES = VALUE_W / 4;
  localparam int unsigned LEN_W   = 5;

  // commands from the sequencer to the nibble scanner
  typedef struct packed {
    logic load;   // take a fresh value, digit count to the full width
    logic step;   // drop a leading zero nibble
    logic shift;  // move on to the next digit
  } hff_scan_ctrl_t;

  // status from the nibble scanner
  typedef struct packed {
    logic [3:0]       nibble;  // most significant nibble still held
    logic [LEN_W-1:0] len;     // significant digits found
    logic             done;    // leading zeros all stripped
  } hff_scan_stat_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [7:0] n8;
    n8 = {4'h0, nib};
    if (nib < 4'd10) begin
      return CH_ZERO + n8;
    end
    return (upper ? CH_A_UPPER : CH_A_LOWER) + n8 - 8'd10;
  endfunction

endpackage

@@ design/hff_if.sv @@
// ---------------------------------------------------------------------------
// hff_if
// valid/ready channels of the formatter: settings in, characters out
// ---------------------------------------------------------------------------
interface hff_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [5:0]  precision;
  logic [5:0]  min_width;
  logic        alt_prefix;
  logic        zero_pad;
  logic        left_justify;
  logic        upper_case;

  modport source (
    output valid, value, precision, min_width, alt_prefix, zero_pad, left_justify,
           upper_case,
    input  ready
  );
  modport sink (
    input  valid, value, precision, min_width, alt_prefix, zero_pad, left_justify,
           upper_case,
    output ready
  );
endinterface

interface hff_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, ch, last, input ready);
  modport sink (input valid, ch, last, output ready);
endinterface

@@ design/hff_scan.sv @@
// ---------------------------------------------------------------------------
// hff_scan
// nibble shifter: strips leading zero digits, then feeds digits msd first
// ---------------------------------------------------------------------------
module hff_scan (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [63:0]             value_i,
  input  hff_pkg::hff_scan_ctrl_t ctrl_i,
  output hff_pkg::hff_scan_stat_t stat_o
);

  logic [hff_pkg::VALUE_W-1:0] sh_q, sh_d;
  logic [hff_pkg::LEN_W-1:0]   len_q, len_d;
  logic                        done;

  assign done = (sh_q[hff_pkg::VALUE_W-1 -: 4] != 4'h0) || (len_q == hff_pkg::LEN_W'(1));

  always_comb begin
    sh_d  = sh_q;
    len_d = len_q;
    if (ctrl_i.load) begin
      sh_d  = value_i;
      len_d = hff_pkg::LEN_W'(hff_pkg::NIBBLES);
    end else if (ctrl_i.step && !done) begin
      sh_d  = {sh_q[hff_pkg::VALUE_W-5:0], 4'h0};
      len_d = len_q - hff_pkg::LEN_W'(1);
    end else if (ctrl_i.shift) begin
      sh_d  = {sh_q[hff_pkg::VALUE_W-5:0], 4'h0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else begin
      len_q <= len_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  assign stat_o.nibble = sh_q[hff_pkg::VALUE_W-1 -: 4];
  assign stat_o.len    = len_q;
  assign stat_o.done   = done;

endmodule

@@ design/hex_field_formatter.sv @@
// ---------------------------------------------------------------------------
// hex_field_formatter
// printf style hex conversion of a 64-bit value, one character per word
// ---------------------------------------------------------------------------
// One input word carries a value and its format settings; the block answers
// with the formatted field, one ascii character per output word, msd first,
// last set on the final character. The field is leading spaces, an optional
// 0x/0X prefix, zero fill, the digits and, when left-justified, trailing
// spaces. Precision and width above MAX_FIELD are saturated to it. The block
// takes one word at a time: after acceptance a single nibble shifter strips
// leading zero digits, one per cycle, the S_CALC state works out the
// padding counts, then the same shifter feeds the digits while the
// sequencer emits one character per cycle the sink takes. The leading
// space run and the zero run each end with a pass through their state
// that emits nothing, even when empty. A field is 64 characters at most.
// ---------------------------------------------------------------------------
module hex_field_formatter #(
  parameter int unsigned MAX_FIELD = 62
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  hff_in_if.sink       in_i,
  hff_out_if.source    out_o
);

  // count width and a signed work width with headroom for differences
  localparam int unsigned CW = $clog2(MAX_FIELD + 1);
  localparam int unsigned SW = CW + 2;
  localparam logic [5:0]  MaxSat = 6'(MAX_FIELD);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_CALC,
    S_LSPC,
    S_PFX0,
    S_PFXX,
    S_ZERO,
    S_DIGIT,
    S_TSPC
  } state_e;

  state_e state_q, state_d;

  // captured settings
  logic [CW-1:0] prec_q, prec_d;
  logic [CW-1:0] width_q, width_d;
  logic          alt_q, alt_d;
  logic          left_q, left_d;
  logic          upper_q, upper_d;
  logic          zm_q, zm_d;

  // run counters
  logic [CW-1:0]             lsp_q, lsp_d;
  logic [CW-1:0]             tsp_q, tsp_d;
  logic [CW-1:0]             zero_q, zero_d;
  logic [hff_pkg::LEN_W-1:0] dig_q, dig_d;

  // output register
  logic       ov_q, ov_d;
  logic [7:0] ch_q, ch_d;
  logic       last_q, last_d;

  hff_pkg::hff_scan_ctrl_t scan_ctrl;
  hff_pkg::hff_scan_stat_t scan_stat;

  logic          out_free;
  logic          emit;
  logic [7:0]    ch_e;
  logic          last_e;
  logic [5:0]    prec_sat, width_sat;

  // padding arithmetic
  logic [SW-1:0] len_w, prec_w, width_w, pfx_w, maxd_w, minw_w;
  logic [SW-1:0] spc_raw, zero_raw;

  hff_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .value_i (in_i.value),
    .ctrl_i  (scan_ctrl),
    .stat_o  (scan_stat)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign out_free   = !ov_q || out_o.ready;

  // oversized settings clamp to the field limit
  assign prec_sat  = (in_i.precision > MaxSat) ? MaxSat : in_i.precision;
  assign width_sat = (in_i.min_width > MaxSat) ? MaxSat : in_i.min_width;

  assign len_w   = SW'(scan_stat.len);
  assign prec_w  = SW'(prec_q);
  assign width_w = SW'(width_q);
  assign pfx_w   = SW'({alt_q, 1'b0});
  assign maxd_w  = (prec_w > len_w) ? prec_w : len_w;
  assign minw_w  = (width_w > len_w) ? width_w : len_w;
  assign spc_raw  = minw_w - maxd_w - pfx_w;
  // zero-pad mode fills to the width after the prefix
  assign zero_raw = zm_q ? (minw_w - len_w - pfx_w) : (maxd_w - len_w);

  always_comb begin
    state_d   = state_q;
    prec_d    = prec_q;
    width_d   = width_q;
    alt_d     = alt_q;
    left_d    = left_q;
    upper_d   = upper_q;
    zm_d      = zm_q;
    lsp_d     = lsp_q;
    tsp_d     = tsp_q;
    zero_d    = zero_q;
    dig_d     = dig_q;
    scan_ctrl = '0;
    emit      = 1'b0;
    ch_e      = hff_pkg::CH_SPACE;
    last_e    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          prec_d         = prec_sat[CW-1:0];
          width_d        = width_sat[CW-1:0];
          alt_d          = in_i.alt_prefix;
          left_d         = in_i.left_justify;
          upper_d        = in_i.upper_case;
          zm_d           = in_i.zero_pad && (in_i.precision == 6'd0);
          scan_ctrl.load = 1'b1;
          state_d        = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_stat.done) begin
          state_d = S_CALC;
        end else begin
          scan_ctrl.step = 1'b1;
        end
      end
      S_CALC: begin
        // negative counts mean no padding; zero-pad mode has no spaces
        if (zm_q || spc_raw[SW-1]) begin
          lsp_d = '0;
          tsp_d = '0;
        end else begin
          lsp_d = left_q ? '0 : spc_raw[CW-1:0];
          tsp_d = left_q ? spc_raw[CW-1:0] : '0;
        end
        zero_d  = zero_raw[SW-1] ? '0 : zero_raw[CW-1:0];
        dig_d   = scan_stat.len;
        state_d = S_LSPC;
      end
      S_LSPC: begin
        if (lsp_q == '0) begin
          state_d = alt_q ? S_PFX0 : S_ZERO;
        end else if (out_free) begin
          emit  = 1'b1;
          ch_e  = hff_pkg::CH_SPACE;
          lsp_d = lsp_q - CW'(1);
        end
      end
      S_PFX0: begin
        if (out_free) begin
          emit    = 1'b1;
          ch_e    = hff_pkg::CH_ZERO;
          state_d = S_PFXX;
        end
      end
      S_PFXX: begin
        if (out_free) begin
          emit    = 1'b1;
          ch_e    = upper_q ? hff_pkg::CH_X_UPPER : hff_pkg::CH_X_LOWER;
          state_d = S_ZERO;
        end
      end
      S_ZERO: begin
        if (zero_q == '0) begin
          state_d = S_DIGIT;
        end else if (out_free) begin
          emit   = 1'b1;
          ch_e   = hff_pkg::CH_ZERO;
          zero_d = zero_q - CW'(1);
        end
      end
      S_DIGIT: begin
        if (out_free) begin
          emit            = 1'b1;
          ch_e            = hff_pkg::hex_char(scan_stat.nibble, upper_q);
          scan_ctrl.shift = 1'b1;
          dig_d           = dig_q - hff_pkg::LEN_W'(1);
          if (dig_q == hff_pkg::LEN_W'(1)) begin
            last_e  = (tsp_q == '0);
            state_d = (tsp_q == '0) ? S_IDLE : S_TSPC;
          end
        end
      end
      S_TSPC: begin
        if (out_free) begin
          emit  = 1'b1;
          ch_e  = hff_pkg::CH_SPACE;
          tsp_d = tsp_q - CW'(1);
          if (tsp_q == CW'(1)) begin
            last_e  = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // output register loads on emit, drains when the sink takes the word
    if (emit) begin
      ov_d   = 1'b1;
      ch_d   = ch_e;
      last_d = last_e;
    end else begin
      ov_d   = ov_q && !out_o.ready;
      ch_d   = ch_q;
      last_d = last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      ch_q    <= '0;
      last_q  <= 1'b0;
      lsp_q   <= '0;
      tsp_q   <= '0;
      zero_q  <= '0;
      dig_q   <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      ch_q    <= ch_d;
      last_q  <= last_d;
      lsp_q   <= lsp_d;
      tsp_q   <= tsp_d;
      zero_q  <= zero_d;
      dig_q   <= dig_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    prec_q  <= prec_d;
    width_q <= width_d;
    alt_q   <= alt_d;
    left_q  <= left_d;
    upper_q <= upper_d;
    zm_q    <= zm_d;
  end

  assign out_o.valid = ov_q;
  assign out_o.ch    = ch_q;
  assign out_o.last  = last_q;

  // a new word starts a scan over all sixteen nibbles
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=>
      (state_q == S_SCAN) && (scan_stat.len == hff_pkg::LEN_W'(hff_pkg::NIBBLES)))
    else $error("accepted word did not start a fresh scan");

  // padding counts are taken only once the leading zeros are gone
  a_calc_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CALC) |-> scan_stat.done)
    else $error("padding worked out before the digit scan finished");

  // digit run never underflows
  a_digit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIGIT) |-> (dig_q != '0))
    else $error("digit state entered with no digits left");

  // the final character returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last_e) |=> (state_q == S_IDLE) && ov_q && last_q)
    else $error("last character emitted without closing the field");

endmodule

@@ tb/sv/hff_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hff_checker
// watches both channels of the formatter, predicts every field, compares
// ---------------------------------------------------------------------------
// Each accepted input word is expanded into the characters of its hex field
// and queued. Each accepted output word is compared, character and last flag,
// with the oldest queued character. The top reads back the counters below.
// ---------------------------------------------------------------------------
module hff_checker #(
  parameter int unsigned MAX_FIELD = 62
) (
  input  logic clk_i,
  input  logic rst_ni,
  hff_in_if    in_i,
  hff_out_if   out_i,
  output int   errors_o,
  output int   pending_o,
  output int   fields_o,
  output int   chars_o,
  output int   longest_o,
  output int   zero_fill_o
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } field_char_t;

  field_char_t field_chars_q[$];

  int mismatches  = 0;
  int fields_seen = 0;
  int chars_seen  = 0;
  int longest     = 0;
  int zero_fills  = 0;
  int out_field   = 0;  // field number on the output side
  int out_pos     = 0;  // character position inside that field

  assign errors_o    = mismatches;
  assign pending_o   = field_chars_q.size();
  assign fields_o    = fields_seen;
  assign chars_o     = chars_seen;
  assign longest_o   = longest;
  assign zero_fill_o = zero_fills;

  function automatic void queue_run(input int count, input logic [7:0] ch);
    for (int k = 0; k < count; k++) begin
      field_chars_q.push_back('{ch: ch, last: 1'b0});
    end
  endfunction

  // expand one value and its settings into the characters of its field
  function automatic void format_hex_field(
    input logic [63:0] value,
    input logic [5:0]  prec_in,
    input logic [5:0]  width_in,
    input logic        alt,
    input logic        zpad,
    input logic        left,
    input logic        upper
  );
    int          prec, width, ndig, maxd, minw, total, pfx, spaces, zeros, start;
    logic [63:0] rest;
    logic [3:0]  nib;
    bit          zero_mode;
    string       glyphs;
    prec   = (prec_in > MAX_FIELD) ? MAX_FIELD : int'(prec_in);
    width  = (width_in > MAX_FIELD) ? MAX_FIELD : int'(width_in);
    glyphs = upper ? "0123456789ABCDEF" : "0123456789abcdef";
    ndig = 1;
    rest = value >> 4;
    while (rest != 64'd0) begin
      ndig++;
      rest = rest >> 4;
    end
    maxd  = (prec > ndig) ? prec : ndig;
    minw  = (width > ndig) ? width : ndig;
    total = (maxd > minw) ? maxd : minw;
    pfx   = alt ? 2 : 0;
    zero_mode = zpad && (prec == 0);
    if (zero_mode) begin
      minw = 0;
      zero_fills++;
    end
    spaces = minw - maxd - pfx;
    zeros  = zero_mode ? (total - ndig - pfx) : (maxd - ndig);
    start  = field_chars_q.size();

    if (!left) queue_run(spaces, hff_pkg::CH_SPACE);
    if (alt) begin
      queue_run(1, hff_pkg::CH_ZERO);
      queue_run(1, upper ? hff_pkg::CH_X_UPPER : hff_pkg::CH_X_LOWER);
    end
    queue_run(zeros, hff_pkg::CH_ZERO);
    for (int i = ndig - 1; i >= 0; i--) begin
      nib = value[4*i +: 4];
      queue_run(1, glyphs[nib]);
    end
    if (left) queue_run(spaces, hff_pkg::CH_SPACE);

    field_chars_q[field_chars_q.size() - 1].last = 1'b1;
    if (field_chars_q.size() - start > longest) longest = field_chars_q.size() - start;
  endfunction

  function automatic void report(input string msg);
    if (mismatches < 10) $display("[%0t] %s", $time, msg);
    mismatches++;
  endfunction

  always @(posedge clk_i) begin : watch
    field_char_t want;
    if (rst_ni) begin
      // input first, so that a same-edge character could still find its field
      if (in_i.valid && in_i.ready) begin
        format_hex_field(in_i.value, in_i.precision, in_i.min_width, in_i.alt_prefix,
                         in_i.zero_pad, in_i.left_justify, in_i.upper_case);
        fields_seen++;
      end
      if (out_i.valid && out_i.ready) begin
        chars_seen++;
        if (field_chars_q.size() == 0) begin
          report($sformatf("char 8'h%02h last %0b with no field outstanding",
                           out_i.ch, out_i.last));
        end else begin
          want = field_chars_q.pop_front();
          if (out_i.ch !== want.ch || out_i.last !== want.last) begin
            report($sformatf("field %0d char %0d: expected 8'h%02h last %0b, got 8'h%02h last %0b",
                             out_field, out_pos, want.ch, want.last, out_i.ch, out_i.last));
          end
          if (want.last) begin
            out_field++;
            out_pos = 0;
          end else begin
            out_pos++;
          end
        end
      end
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the hex field formatter
// ---------------------------------------------------------------------------
// Sends a directed set of fields (value and settings extremes, every special
// case of the padding rules) and then random fields, with random gaps on the
// input side and random stalls on the output side. A long output stall with
// back-to-back input words fills the block up. Checking is in hff_checker.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int unsigned MAX_FIELD  = 62;
  localparam int          N_RANDOM   = 444;
  localparam int          LONG_HOLD  = 400;        // output stall for the fill-up test
  localparam int          DRAIN      = 200;        // > longest field plus digit scan
  localparam int          LIMIT      = 6_000_000;  // cycles before giving up

  // one input word as the sender sees it
  typedef struct packed {
    logic [63:0] value;
    logic [5:0]  precision;
    logic [5:0]  min_width;
    logic        alt_prefix;
    logic        zero_pad;
    logic        left_justify;
    logic        upper_case;
  } fmt_req_t;

  logic clk;
  logic rst_n;

  hff_in_if  in_if ();
  hff_out_if out_if ();

  // shared between the two sides
  bit quiet         = 1'b0;  // no idling on either side while set, but the long stall still goes first
  bit long_hold_req = 1'b0;  // sender asks the receiver for one long stall
  int sent          = 0;
  int held_cycles   = 0;
  int cycles        = 0;

  int errors, pending, fields, chars, longest, zero_fills;

  hex_field_formatter #(
    .MAX_FIELD (MAX_FIELD)
  ) i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  hff_checker #(
    .MAX_FIELD (MAX_FIELD)
  ) i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_if),
    .out_i       (out_if),
    .errors_o    (errors),
    .pending_o   (pending),
    .fields_o    (fields),
    .chars_o     (chars),
    .longest_o   (longest),
    .zero_fill_o (zero_fills)
  );

  // clock and a single reset at the start
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // safety net: a hung handshake ends the run here
  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("run timed out after %0d cycles, %0d fields sent, %0d chars pending",
             cycles, sent, pending);
    $display("TB_ERROR");
    $finish;
  end

  // idle length: mostly none, often a few cycles, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic fmt_req_t mk(input logic [63:0] value, input int prec, input int width,
                                  input bit alt, input bit zpad, input bit left,
                                  input bit upper);
    fmt_req_t f;
    f.value        = value;
    f.precision    = prec[5:0];
    f.min_width    = width[5:0];
    f.alt_prefix   = alt;
    f.zero_pad     = zpad;
    f.left_justify = left;
    f.upper_case   = upper;
    return f;
  endfunction

  // random field: digit counts spread evenly, sizes mostly small
  function automatic fmt_req_t random_field();
    fmt_req_t    f;
    logic [63:0] v;
    int          ndig, r;
    r    = $urandom_range(0, 99);
    ndig = $urandom_range(0, 16);
    v    = {$urandom(), $urandom()};
    if (r < 4) v = '1;
    else if (r < 8) v = 64'd1 << $urandom_range(0, 63);
    else if (ndig == 0) v = '0;
    else v = v >> (64 - 4 * ndig);
    f.value = v;
    // no precision often, so that zero fill and the default path get plenty
    r = $urandom_range(0, 99);
    if (r < 45) f.precision = '0;
    else if (r < 85) f.precision = 6'($urandom_range(1, 20));
    else f.precision = 6'($urandom_range(21, 63));
    r = $urandom_range(0, 99);
    if (r < 25) f.min_width = '0;
    else if (r < 80) f.min_width = 6'($urandom_range(1, 24));
    else f.min_width = 6'($urandom_range(25, 63));
    {f.alt_prefix, f.zero_pad, f.left_justify, f.upper_case} = 4'($urandom());
    return f;
  endfunction

  // offer one word and hold it until taken; ready is looked at on the
  // falling edge so the decision never races the block's own update
  task automatic send_field(input fmt_req_t f);
    int n;
    in_if.valid        <= 1'b1;
    in_if.value        <= f.value;
    in_if.precision    <= f.precision;
    in_if.min_width    <= f.min_width;
    in_if.alt_prefix   <= f.alt_prefix;
    in_if.zero_pad     <= f.zero_pad;
    in_if.left_justify <= f.left_justify;
    in_if.upper_case   <= f.upper_case;
    forever begin
      @(negedge clk);
      if (in_if.ready) break;
    end
    @(posedge clk);
    sent++;
    // valid stays up for a back-to-back word, otherwise drops for the gap
    n = quiet ? 0 : gap_len();
    if (n > 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // receiver: random stalls, idle-free stretches and the one long hold-off
  initial begin : sink_side
    int n;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        held_cycles   += LONG_HOLD;
        long_hold_req  = 1'b0;
      end else if (quiet) begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end else begin
        n = gap_len();
        if (n == 0) begin
          out_if.ready <= 1'b1;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end else begin
          out_if.ready <= 1'b0;
          held_cycles += n;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  // stimulus and verdict
  initial begin : source_side
    int n_directed;
    in_if.valid        <= 1'b0;
    in_if.value        <= '0;
    in_if.precision    <= '0;
    in_if.min_width    <= '0;
    in_if.alt_prefix   <= 1'b0;
    in_if.zero_pad     <= 1'b0;
    in_if.left_justify <= 1'b0;
    in_if.upper_case   <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);

    // value zero: bare digit, prefix still emitted, both cases
    send_field(mk(64'd0, 0, 0, 0, 0, 0, 0));
    send_field(mk(64'd0, 0, 0, 1, 0, 0, 0));
    send_field(mk(64'd0, 0, 0, 1, 0, 0, 1));
    // widest values and every digit glyph in both cases
    send_field(mk('1, 0, 0, 0, 0, 0, 0));
    send_field(mk('1, 0, 0, 1, 0, 0, 1));
    send_field(mk(64'h0123_4567_89ab_cdef, 0, 0, 0, 0, 0, 0));
    send_field(mk(64'hfedc_ba98_7654_3210, 0, 0, 1, 0, 0, 1));
    // oversized precision and width saturate, longest possible field
    send_field(mk(64'd1, 63, 63, 1, 0, 0, 0));
    send_field(mk(64'd1, 0, 63, 0, 0, 0, 0));
    send_field(mk(64'd1, 0, 63, 0, 0, 1, 0));
    // zero fill without precision, with prefix, and ignoring left-justify
    send_field(mk(64'habc, 0, 20, 0, 1, 0, 0));
    send_field(mk(64'habc, 0, 20, 1, 1, 0, 0));
    send_field(mk(64'habc, 0, 20, 1, 1, 1, 1));
    // zero fill with a precision: precision wins, spaces stay
    send_field(mk(64'habc, 5, 20, 0, 1, 0, 0));
    // prefix plus digits wider than the field: no padding at all
    send_field(mk(64'habc, 0, 3, 1, 0, 0, 0));
    send_field(mk(64'habc, 0, 4, 1, 1, 0, 0));
    send_field(mk(64'habc, 0, 4, 1, 0, 1, 0));
    // precision below the digit count
    send_field(mk(64'habc, 2, 0, 0, 0, 0, 0));
    // precision, width, prefix and left-justify together; then prefix with zero fill
    send_field(mk(64'habc, 8, 12, 1, 0, 1, 0));
    send_field(mk(64'h5, 3, 10, 1, 0, 1, 1));
    send_field(mk(64'h8000_0000_0000_0000, 0, 63, 1, 1, 0, 1));
    // all-zero fields of maximum length, then a one-digit field
    send_field(mk(64'd0, 0, 63, 0, 1, 0, 0));
    send_field(mk(64'd0, 63, 0, 0, 0, 0, 0));
    send_field(mk(64'd1, 1, 1, 0, 0, 0, 0));
    n_directed = sent;

    // fill-up: receiver stalls for a long stretch, sender keeps pushing
    long_hold_req = 1'b1;
    quiet         = 1'b1;
    repeat (12) send_field(random_field());
    quiet = 1'b0;

    // random part, with an idle-free stretch in the middle
    for (int k = 0; k < N_RANDOM; k++) begin
      quiet = (k >= 160 && k < 240);
      send_field(random_field());
    end
    quiet = 1'b0;
    in_if.valid <= 1'b0;

    // wait for the last field, then a little longer to catch stray words
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN) @(posedge clk);

    $display("%0d fields sent (%0d directed), %0d characters checked, longest field %0d",
             sent, n_directed, chars, longest);
    $display("%0d fields with zero fill, receiver stalled %0d cycles, %0d mismatches",
             zero_fills, held_cycles, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
